/* hw/rtl/block_config_text_tokenizer_core_assert.svh */
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared forms for concurrent checks on the tokenizer ports.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CONFIG_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define BLOCK_CONFIG_TEXT_TOKENIZER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BCTT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bctt same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BCTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bctt next-cycle check failed");

`endif

/* hw/rtl/bctt_pkg.sv */
// ----------------------------------------------------------------------------
// bctt_pkg
// Types, character codes and helpers for the block config text tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bctt_pkg;

	localparam int unsigned ERR_LINE_W = 16;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [2:0] {
		MODE_SEARCH = 3'd0,
		MODE_NAME   = 3'd1,
		MODE_BLOCK  = 3'd2,
		MODE_KEY    = 3'd3,
		MODE_VALUE  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CLS_SKIP  = 2'd0,
		CLS_NAME  = 2'd1,
		CLS_KEY   = 2'd2,
		CLS_VALUE = 2'd3
	} class_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_STRAY_CLOSE = 3'd1,
		ERR_STRAY_SEMI  = 3'd2,
		ERR_STRAY_COLON = 3'd3,
		ERR_STRAY_OPEN  = 3'd4,
		ERR_EMPTY_VALUE = 3'd5,
		ERR_EOF_IN_BLK  = 3'd6
	} err_t;

	typedef struct packed {
		mode_t mode;
		logic  escape_pending;
		logic  comment_active;
		logic  value_started;
		err_t  sticky_error;
	} state_t;

	typedef struct packed {
		logic [7:0]            byte_out;
		class_t                byte_class;
		logic                  entry_end;
		logic                  block_end;
		err_t                  error_code;
		logic [ERR_LINE_W-1:0] error_line;
		logic                  parse_ok;
	} result_t;

	// delimiter that does not belong in the given mode
	function automatic err_t stray_code(input logic [7:0] c, input mode_t mode);
		err_t e;
		e = ERR_NONE;
		if (c == CH_RBRACE && mode != MODE_BLOCK) begin
			e = ERR_STRAY_CLOSE;
		end else if (c == CH_SEMI && mode != MODE_VALUE) begin
			e = ERR_STRAY_SEMI;
		end else if (c == CH_COLON && mode != MODE_KEY) begin
			e = ERR_STRAY_COLON;
		end else if (c == CH_LBRACE && mode != MODE_NAME) begin
			e = ERR_STRAY_OPEN;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bctt_stream_if.sv */
// ----------------------------------------------------------------------------
// bctt stream interfaces
// Valid/ready channels for text bytes in and tagged tokens out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bctt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source (output valid, output byte_in, output end_of_input, input ready);
	modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface bctt_token_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic [1:0]  byte_class;
	logic        entry_end;
	logic        block_end;
	logic [2:0]  error_code;
	logic [15:0] error_line;
	logic        parse_ok;

	modport source (
		output valid, output byte_out, output byte_class, output entry_end,
		output block_end, output error_code, output error_line, output parse_ok,
		input ready
	);
	modport sink (
		input valid, input byte_out, input byte_class, input entry_end,
		input block_end, input error_code, input error_line, input parse_ok,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/block_config_text_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// block_config_text_tokenizer_core
// Tags each byte of name{key:value;...} text and tracks syntax errors.
//
// channel  dir  modport  beat
// text     in   sink     one byte or end-of-input mark
// token    out  source   tagged byte, entry/block ends, error status
//
// one beat per cycle sustained while token.ready is high; a text beat's token is valid the next cycle
// state and token register update on the same edge, no other latency
// text.ready drops only while a token waits and token.ready is low
// arst_n clears parse state, line count (to 1) and token valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_config_text_tokenizer_core #(
	parameter int unsigned LINE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	bctt_text_if.sink           text,
	bctt_token_if.source        token
);
	import bctt_pkg::*;

	localparam state_t STATE_RESET = '{
		mode:           MODE_SEARCH,
		escape_pending: 1'b0,
		comment_active: 1'b0,
		value_started:  1'b0,
		sticky_error:   ERR_NONE
	};

	state_t               state_q;
	state_t               state_nxt;
	logic [LINE_BITS-1:0] line_q;
	logic [LINE_BITS-1:0] line_nxt;
	result_t              res_nxt;
	result_t              res_q;
	logic                 out_valid_q;
	logic                 accept;

	assign text.ready = !out_valid_q || token.ready;
	assign accept     = text.valid && text.ready;

	bctt_parse #(
		.LINE_BITS(LINE_BITS)
	) u_parse (
		.cur          (state_q),
		.line_cur     (line_q),
		.byte_in      (text.byte_in),
		.end_of_input (text.end_of_input),
		.nxt          (state_nxt),
		.line_nxt     (line_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			line_q      <= LINE_BITS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				line_q      <= line_nxt;
				out_valid_q <= 1'b1;
			end else if (token.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign token.valid      = out_valid_q;
	assign token.byte_out   = res_q.byte_out;
	assign token.byte_class = res_q.byte_class;
	assign token.entry_end  = res_q.entry_end;
	assign token.block_end  = res_q.block_end;
	assign token.error_code = res_q.error_code;
	assign token.error_line = res_q.error_line;
	assign token.parse_ok   = res_q.parse_ok;

endmodule

`default_nettype wire

/* hw/rtl/bctt_parse.sv */
// ----------------------------------------------------------------------------
// bctt_parse
// Next-state and token logic for one text byte or end-of-input mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bctt_parse #(
	parameter int unsigned LINE_BITS = 16
) (
	input  bctt_pkg::state_t        cur,
	input  logic [LINE_BITS-1:0]    line_cur,
	input  logic [7:0]              byte_in,
	input  logic                    end_of_input,
	output bctt_pkg::state_t        nxt,
	output logic [LINE_BITS-1:0]    line_nxt,
	output bctt_pkg::result_t       res
);
	import bctt_pkg::*;

	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

	logic [ERR_LINE_W-1:0] line_clamped;
	err_t                  err;
	logic                  blank;

	assign blank = (byte_in == CH_SPACE) || (byte_in == CH_TAB);

	always_comb begin
		nxt      = cur;
		line_nxt = line_cur;
		err      = ERR_NONE;
		res.byte_out   = byte_in;
		res.byte_class = CLS_SKIP;
		res.entry_end  = 1'b0;
		res.block_end  = 1'b0;
		res.parse_ok   = 1'b0;

		if (end_of_input) begin
			res.byte_out = 8'd0;
			if (cur.sticky_error == ERR_NONE && cur.mode != MODE_SEARCH) begin
				nxt.sticky_error = ERR_EOF_IN_BLK;
			end
			res.parse_ok = (nxt.sticky_error == ERR_NONE);
		end else if (cur.sticky_error != ERR_NONE) begin
			// frozen after an error
		end else if (byte_in == CH_LF) begin
			if (line_cur != LINE_MAX) begin
				line_nxt = line_cur + LINE_BITS'(1);
			end
			nxt.comment_active = 1'b0;
			nxt.escape_pending = 1'b0;
		end else if (cur.comment_active) begin
			// inside comment
		end else if (cur.escape_pending) begin
			nxt.escape_pending = 1'b0;
			nxt.value_started  = 1'b1;
			res.byte_class     = CLS_VALUE;
		end else if (byte_in == CH_HASH) begin
			nxt.comment_active = 1'b1;
		end else if (blank && !(cur.mode == MODE_VALUE && cur.value_started)) begin
			// blank outside a started value
		end else begin
			case (cur.mode)
				MODE_NAME: begin
					if (byte_in == CH_LBRACE) begin
						nxt.mode = MODE_BLOCK;
					end else begin
						err = stray_code(byte_in, MODE_NAME);
						if (err == ERR_NONE) res.byte_class = CLS_NAME;
					end
				end
				MODE_BLOCK: begin
					if (byte_in == CH_RBRACE) begin
						res.block_end     = 1'b1;
						nxt.mode          = MODE_SEARCH;
						nxt.value_started = 1'b0;
					end else begin
						err = stray_code(byte_in, MODE_BLOCK);
						if (err == ERR_NONE) begin
							res.byte_class = CLS_KEY;
							nxt.mode       = MODE_KEY;
						end
					end
				end
				MODE_KEY: begin
					if (byte_in == CH_COLON) begin
						nxt.mode          = MODE_VALUE;
						nxt.value_started = 1'b0;
					end else begin
						err = stray_code(byte_in, MODE_KEY);
						if (err == ERR_NONE) res.byte_class = CLS_KEY;
					end
				end
				MODE_VALUE: begin
					if (byte_in == CH_SEMI) begin
						if (!cur.value_started) begin
							err = ERR_EMPTY_VALUE;
						end else begin
							res.entry_end     = 1'b1;
							nxt.mode          = MODE_BLOCK;
							nxt.value_started = 1'b0;
						end
					end else if (byte_in == CH_BSLASH) begin
						nxt.escape_pending = 1'b1;
					end else begin
						err = stray_code(byte_in, MODE_VALUE);
						if (err == ERR_NONE) begin
							res.byte_class    = CLS_VALUE;
							nxt.value_started = 1'b1;
						end
					end
				end
				default: begin
					// searching, and unreachable codes
					err = stray_code(byte_in, MODE_SEARCH);
					if (err == ERR_NONE) begin
						res.byte_class = CLS_NAME;
						nxt.mode       = MODE_NAME;
					end
				end
			endcase
			if (err != ERR_NONE) nxt.sticky_error = err;
		end

		res.error_code = nxt.sticky_error;
		res.error_line = (nxt.sticky_error != ERR_NONE) ? line_clamped : '0;
	end

	generate
		if (LINE_BITS > ERR_LINE_W) begin : g_clamp
			assign line_clamped = (|line_nxt[LINE_BITS-1:ERR_LINE_W]) ?
				{ERR_LINE_W{1'b1}} : line_nxt[ERR_LINE_W-1:0];
		end else begin : g_extend
			assign line_clamped = ERR_LINE_W'(line_nxt);
		end
	endgenerate

endmodule

`default_nettype wire

/* hw/rtl/bctt_checker.sv */
// ----------------------------------------------------------------------------
// bctt_checker
// Port-level checks on the tokenizer, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_config_text_tokenizer_core_assert.svh"

module bctt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  byte_class,
	input  logic [2:0]  error_code,
	input  logic [15:0] error_line,
	input  logic        parse_ok
);
	import bctt_pkg::*;

	logic       in_beat;
	logic       out_beat;
	logic [2:0] last_err_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// error code seen on the last delivered token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= ERR_NONE;
		end else if (out_beat) begin
			last_err_q <= error_code;
		end
	end

	`BCTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`BCTT_ASSERT_SAME(a_no_take_when_full, clk, arst_n, out_valid && !out_ready, !in_ready)
	`BCTT_ASSERT_NEXT(a_token_follows, clk, arst_n, in_beat, out_valid)
	`BCTT_ASSERT_SAME(a_error_sticky, clk, arst_n, out_beat && last_err_q != ERR_NONE, error_code == last_err_q)
	`BCTT_ASSERT_SAME(a_char_no_error, clk, arst_n, out_beat && byte_class != CLS_SKIP, error_code == ERR_NONE && error_line == 16'd0 && !parse_ok)

endmodule

bind block_config_text_tokenizer_core bctt_checker u_bctt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (text.valid),
	.in_ready   (text.ready),
	.out_valid  (token.valid),
	.out_ready  (token.ready),
	.byte_class (token.byte_class),
	.error_code (token.error_code),
	.error_line (token.error_line),
	.parse_ok   (token.parse_ok)
);

`default_nettype wire

/* tb/tb_block_config_text_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// tb_block_config_text_tokenizer_core
// Self-checking bench for the block config text tokenizer. A short table of
// directed text bytes is followed by randomly built name{key:value;} blocks
// with blanks, comments, line ends and escapes mixed in. The run closes with
// one broken sequence and the frozen parse that follows it. Every token beat
// is compared field by field with a typed row or an in-bench tokenizer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_config_text_tokenizer_core;

	import bctt_pkg::*;

	localparam int RANDOM_BEATS   = 1000;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
		logic       typed;
		class_t     cls;
		logic       ent;
		logic       blk;
		logic       ok;
	} dir_row_t;

	// typed rows carry their token by hand, the rest go through the model
	localparam dir_row_t DIR_ROWS [23] = '{
		'{8'hA5,     1'b1, 1'b1, CLS_SKIP,  1'b0, 1'b0, 1'b1},
		'{8'hFF,     1'b0, 1'b1, CLS_NAME,  1'b0, 1'b0, 1'b0},
		'{8'h00,     1'b0, 1'b1, CLS_NAME,  1'b0, 1'b0, 1'b0},
		'{CH_SPACE,  1'b0, 1'b1, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_LBRACE, 1'b0, 1'b1, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_HASH,   1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_RBRACE, 1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_LF,     1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{8'h6B,     1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_TAB,    1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_COLON,  1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_SPACE,  1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_LF,     1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_SEMI,   1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_SPACE,  1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_HASH,   1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{8'h80,     1'b0, 1'b0, CLS_SKIP,  1'b0, 1'b0, 1'b0},
		'{CH_SEMI,   1'b0, 1'b1, CLS_SKIP,  1'b1, 1'b0, 1'b0},
		'{CH_RBRACE, 1'b0, 1'b1, CLS_SKIP,  1'b0, 1'b1, 1'b0},
		'{8'h3C,     1'b1, 1'b1, CLS_SKIP,  1'b0, 1'b0, 1'b1}
	};

	logic clk;
	logic arst_n;

	bctt_text_if  text_ch ();
	bctt_token_if token_ch ();

	block_config_text_tokenizer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	// model state
	mode_t       tk_mode = MODE_SEARCH;
	logic        tk_esc  = 1'b0;
	logic        tk_cmt  = 1'b0;
	logic        tk_vst  = 1'b0;
	err_t        tk_err  = ERR_NONE;
	logic [15:0] tk_line = 16'd1;

	result_t pending_tokens [$];
	int      mismatches  = 0;
	int      text_beats  = 0;
	int      idle_cycles = 0;
	int      stall_left  = 0;
	logic    bursty      = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic err_t misplaced_err(input logic [7:0] b, input mode_t m);
		if (b == CH_RBRACE && m != MODE_BLOCK) return ERR_STRAY_CLOSE;
		if (b == CH_SEMI && m != MODE_VALUE) return ERR_STRAY_SEMI;
		if (b == CH_COLON && m != MODE_KEY) return ERR_STRAY_COLON;
		if (b == CH_LBRACE && m != MODE_NAME) return ERR_STRAY_OPEN;
		return ERR_NONE;
	endfunction

	function automatic result_t tokenize_byte(input logic [7:0] b, input logic eoi);
		result_t r;
		mode_t   m;
		err_t    e;
		r = '0;
		m = tk_mode;
		e = ERR_NONE;
		if (eoi) begin
			if (tk_err == ERR_NONE && m != MODE_SEARCH) tk_err = ERR_EOF_IN_BLK;
			r.parse_ok = (tk_err == ERR_NONE);
		end else if (tk_err != ERR_NONE) begin
			// frozen
		end else if (b == CH_LF) begin
			if (tk_line != 16'hFFFF) tk_line = tk_line + 16'd1;
			tk_cmt = 1'b0;
			tk_esc = 1'b0;
		end else if (tk_cmt) begin
			// inside a comment
		end else if (tk_esc) begin
			tk_esc = 1'b0;
			tk_vst = 1'b1;
			r.byte_class = CLS_VALUE;
		end else if (b == CH_HASH) begin
			tk_cmt = 1'b1;
		end else if ((b == CH_SPACE || b == CH_TAB) && !(m == MODE_VALUE && tk_vst)) begin
			// blank outside a started value
		end else begin
			case (m)
				MODE_NAME: begin
					if (b == CH_LBRACE) m = MODE_BLOCK;
					else begin
						e = misplaced_err(b, m);
						if (e == ERR_NONE) r.byte_class = CLS_NAME;
					end
				end
				MODE_BLOCK: begin
					if (b == CH_RBRACE) begin
						r.block_end = 1'b1;
						m = MODE_SEARCH;
						tk_vst = 1'b0;
					end else begin
						e = misplaced_err(b, m);
						if (e == ERR_NONE) begin
							r.byte_class = CLS_KEY;
							m = MODE_KEY;
						end
					end
				end
				MODE_KEY: begin
					if (b == CH_COLON) begin
						m = MODE_VALUE;
						tk_vst = 1'b0;
					end else begin
						e = misplaced_err(b, m);
						if (e == ERR_NONE) r.byte_class = CLS_KEY;
					end
				end
				MODE_VALUE: begin
					if (b == CH_SEMI) begin
						if (!tk_vst) e = ERR_EMPTY_VALUE;
						else begin
							r.entry_end = 1'b1;
							m = MODE_BLOCK;
							tk_vst = 1'b0;
						end
					end else if (b == CH_BSLASH) begin
						tk_esc = 1'b1;
					end else begin
						e = misplaced_err(b, m);
						if (e == ERR_NONE) begin
							r.byte_class = CLS_VALUE;
							tk_vst = 1'b1;
						end
					end
				end
				default: begin
					e = misplaced_err(b, MODE_SEARCH);
					if (e == ERR_NONE) begin
						r.byte_class = CLS_NAME;
						m = MODE_NAME;
					end
				end
			endcase
			if (e != ERR_NONE) tk_err = e;
		end
		tk_mode = m;
		r.byte_out = eoi ? 8'h00 : b;
		r.error_code = tk_err;
		r.error_line = (tk_err != ERR_NONE) ? tk_line : '0;
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_beat(input logic [7:0] b, input logic eoi, input logic typed,
			input result_t want);
		result_t predicted;
		if (bursty && $urandom_range(0, 3) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		text_ch.valid        <= 1'b1;
		text_ch.byte_in      <= b;
		text_ch.end_of_input <= eoi;
		do @(posedge clk); while (!text_ch.ready);
		predicted = tokenize_byte(b, eoi);
		pending_tokens.push_back(typed ? want : predicted);
		text_beats++;
		@(negedge clk);
	endtask

	task automatic put_byte(input logic [7:0] b);
		send_beat(b, 1'b0, 1'b0, '0);
	endtask

	task automatic put_eof();
		send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b inside {CH_LF, CH_TAB, CH_SPACE, CH_HASH, CH_COLON, CH_SEMI,
				CH_BSLASH, CH_LBRACE, CH_RBRACE});
		return b;
	endfunction

	function automatic logic [7:0] non_lf_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
		return b;
	endfunction

	// blanks, line ends and comments, legal between any two tokens
	task automatic put_filler();
		case ($urandom_range(0, 7))
			0: put_byte(CH_SPACE);
			1: put_byte(CH_TAB);
			2: put_byte(CH_LF);
			3: begin
				put_byte(CH_HASH);
				repeat ($urandom_range(0, 8)) put_byte(non_lf_byte());
				put_byte(CH_LF);
			end
			default: ;
		endcase
	endtask

	task automatic put_value_item(input logic first);
		int pick;
		pick = $urandom_range(first ? 0 : 0, first ? 1 : 4);
		case (pick)
			0: put_byte(plain_byte());
			1: begin
				put_byte(CH_BSLASH);
				put_byte(non_lf_byte());
			end
			2: put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			3: put_filler();
			default: put_byte(plain_byte());
		endcase
	endtask

	task automatic put_text_block();
		put_filler();
		if ($urandom_range(0, 3) == 0) put_eof();
		repeat ($urandom_range(1, 4)) begin
			put_byte(plain_byte());
			put_filler();
		end
		put_byte(CH_LBRACE);
		put_filler();
		repeat ($urandom_range(0, 4)) begin
			repeat ($urandom_range(1, 3)) begin
				put_byte(plain_byte());
				put_filler();
			end
			put_byte(CH_COLON);
			put_filler();
			put_value_item(1'b1);
			repeat ($urandom_range(0, 3)) put_value_item(1'b0);
			put_filler();
			put_byte(CH_SEMI);
			put_filler();
		end
		put_byte(CH_RBRACE);
	endtask

	// leaves the parse part way into a block; depth 0 sends nothing
	task automatic open_partial(input int depth);
		if (depth >= 1) put_byte(plain_byte());
		if (depth >= 2) put_byte(CH_LBRACE);
		if (depth >= 3) put_byte(plain_byte());
		if (depth >= 4) begin
			put_byte(CH_COLON);
			put_byte(plain_byte());
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// token sink stalls
	always @(negedge clk) begin
		if (stall_left != 0) begin
			token_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (bursty && $urandom_range(0, 4) == 0) begin
			token_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			token_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (pending_tokens.size() == 0) begin
				$error("token beat with none expected: byte_out %0d", token_ch.byte_out);
				mismatches++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("byte_out", 32'(want.byte_out), 32'(token_ch.byte_out));
				check_field("byte_class", 32'(want.byte_class), 32'(token_ch.byte_class));
				check_field("entry_end", 32'(want.entry_end), 32'(token_ch.entry_end));
				check_field("block_end", 32'(want.block_end), 32'(token_ch.block_end));
				check_field("error_code", 32'(want.error_code), 32'(token_ch.error_code));
				check_field("error_line", 32'(want.error_line), 32'(token_ch.error_line));
				check_field("parse_ok", 32'(want.parse_ok), 32'(token_ch.parse_ok));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		result_t want;
		int      kind;
		arst_n               = 1'b0;
		text_ch.valid        = 1'b0;
		text_ch.byte_in      = 8'h00;
		text_ch.end_of_input = 1'b0;
		token_ch.ready       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		bursty = 1'b1;
		foreach (DIR_ROWS[i]) begin
			want = '0;
			want.byte_out   = DIR_ROWS[i].eoi ? 8'h00 : DIR_ROWS[i].b;
			want.byte_class = DIR_ROWS[i].cls;
			want.entry_end  = DIR_ROWS[i].ent;
			want.block_end  = DIR_ROWS[i].blk;
			want.parse_ok   = DIR_ROWS[i].ok;
			send_beat(DIR_ROWS[i].b, DIR_ROWS[i].eoi, DIR_ROWS[i].typed, want);
		end

		// hold the text side until the token queue runs dry
		text_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		@(negedge clk);

		while (text_beats < RANDOM_BEATS) begin
			bursty = ($urandom_range(0, 3) != 0);
			put_text_block();
		end

		// no idling from here on
		bursty = 1'b0;
		kind = $urandom_range(0, 2);
		case (kind)
			0: begin
				open_partial(3);
				put_byte(CH_COLON);
				put_byte(CH_SPACE);
				put_byte(CH_SEMI);
			end
			1: begin
				open_partial($urandom_range(1, 4));
				put_eof();
			end
			default: begin
				open_partial($urandom_range(0, 4));
				while (tk_err == ERR_NONE) begin
					case ($urandom_range(0, 3))
						0: put_byte(CH_RBRACE);
						1: put_byte(CH_SEMI);
						2: put_byte(CH_COLON);
						default: put_byte(CH_LBRACE);
					endcase
				end
			end
		endcase
		// parse is frozen now
		repeat (20) put_byte(8'($urandom_range(0, 255)));
		put_eof();

		text_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_tokens.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
